// ===== hdl/sld_pkg.sv =====
// Shared types and constants for the spin loop detector.
`timescale 1ns / 1ps
`default_nettype none

package sld_pkg;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_ABSENT = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [63:0] BUSY_THRESHOLD_RESET = 64'd2000000;
  localparam logic [63:0] WINDOW_WIDTH_RESET   = 64'd4096;

  localparam logic       REG_BUSY_THRESHOLD = 1'b0;
  localparam logic       REG_WINDOW_WIDTH   = 1'b1;

  localparam logic [7:0] TICK_MAX = 8'd255;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  slot_index;
    logic [63:0] pc_value;
    logic [63:0] retired_count;
  } sld_in_t;

  typedef struct packed {
    logic        spin_report;
    logic        busy_tick;
    logic [63:0] count_delta;
    logic [63:0] window_low;
    logic [63:0] window_high;
    logic [63:0] window_span;
  } sld_out_t;

  // One slot record as stored in the record memory.
  typedef struct packed {
    logic [63:0] previous_count;
    logic [63:0] low_mark;
    logic [63:0] high_mark;
    logic [7:0]  busy_ticks;
    logic        reported_flag;
  } sld_rec_t;

  // Update decision handed from the update logic to the write port.
  typedef struct packed {
    logic     write;
    sld_rec_t rec;
    sld_out_t result;
  } sld_upd_t;

endpackage

`default_nettype wire

// ===== hdl/sld_record_mem.sv =====
// Slot record memory: one write port, one registered read port, per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none

module sld_record_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output sld_pkg::sld_rec_t      rd_rec,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire sld_pkg::sld_rec_t wr_rec
);
  import sld_pkg::*;

  sld_rec_t   mem [DEPTH];
  logic       entry_valid [DEPTH];
  sld_rec_t   rd_data;
  logic       rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Unwritten entries read as the zero record.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        entry_valid[i] <= 1'b0;
      end
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= entry_valid[rd_addr];
      end
    end
  end

  assign rd_rec = rd_valid ? rd_data : '0;

endmodule

`default_nettype wire

// ===== hdl/sld_update.sv =====
// Per-item record update: delta, busy test, window tracking, report latch, absent and clear.
`timescale 1ns / 1ps
`default_nettype none

module sld_update #(
  parameter int DEPTH          = 256,
  parameter int TICKS_REQUIRED = 4
) (
  input  wire sld_pkg::sld_in_t  item,
  input  wire sld_pkg::sld_rec_t rec,
  input  wire logic [63:0]       busy_threshold,
  input  wire logic [63:0]       window_width,
  output sld_pkg::sld_upd_t      upd
);
  import sld_pkg::*;

  localparam logic [8:0] SLOT_LIMIT = 9'(DEPTH);
  localparam logic [7:0] TICK_GOAL  = 8'(TICKS_REQUIRED);

  logic        in_range;
  logic [63:0] delta;
  logic        busy;
  logic [63:0] lo;
  logic [63:0] hi;
  logic [63:0] span;
  logic [7:0]  ticks;
  logic        wide;

  always_comb begin
    in_range = {1'b0, item.slot_index} < SLOT_LIMIT;
    delta    = item.retired_count - rec.previous_count;
    busy     = delta > busy_threshold;

    // Seed on the first busy tick, else widen.
    if (rec.busy_ticks == 8'd0) begin
      lo = item.pc_value;
      hi = item.pc_value;
    end else begin
      lo = (item.pc_value < rec.low_mark)  ? item.pc_value : rec.low_mark;
      hi = (item.pc_value > rec.high_mark) ? item.pc_value : rec.high_mark;
    end
    span  = hi - lo;
    ticks = (rec.busy_ticks == TICK_MAX) ? TICK_MAX : rec.busy_ticks + 8'd1;
    wide  = span >= window_width;

    upd.write  = 1'b0;
    upd.rec    = rec;
    upd.result = '0;

    if (in_range) begin
      case (item.command)
        CMD_SAMPLE: begin
          upd.write                 = 1'b1;
          upd.rec.previous_count    = item.retired_count;
          upd.result.count_delta    = delta;
          if (!busy) begin
            upd.rec.busy_ticks    = 8'd0;
            upd.rec.reported_flag = 1'b0;
          end else begin
            upd.result.busy_tick = 1'b1;
            if (wide) begin
              upd.rec.low_mark       = item.pc_value;
              upd.rec.high_mark      = item.pc_value;
              upd.rec.busy_ticks     = 8'd1;
              upd.rec.reported_flag  = 1'b0;
              upd.result.window_low  = item.pc_value;
              upd.result.window_high = item.pc_value;
            end else begin
              upd.rec.low_mark       = lo;
              upd.rec.high_mark      = hi;
              upd.rec.busy_ticks     = ticks;
              upd.result.window_low  = lo;
              upd.result.window_high = hi;
              upd.result.window_span = span;
              if (ticks >= TICK_GOAL && !rec.reported_flag) begin
                upd.rec.reported_flag  = 1'b1;
                upd.result.spin_report = 1'b1;
              end
            end
          end
        end
        CMD_ABSENT: begin
          upd.write             = 1'b1;
          upd.rec.busy_ticks    = 8'd0;
          upd.rec.reported_flag = 1'b0;
        end
        CMD_CLEAR: begin
          upd.write = 1'b1;
          upd.rec   = '0;
        end
        default: begin
          upd.write = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/spin_loop_detector_core.sv =====
// Top level of the spin loop detector: handshakes, config registers, record pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Throughput: 1 item per cycle while results are taken; each slot record is read
//   once and written at most once per item through the single read and single write port
//   of the record memory.
// Reset (rst, synchronous): pipeline and output empty, config registers at reset values,
//   all per-slot valid bits cleared, so every slot reads as a zero record.

module spin_loop_detector_core #(
  parameter int SLOT_COUNT     = 256,
  parameter int TICKS_REQUIRED = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // sample channel
  input  wire logic              sample_valid,
  output logic                   sample_ready,
  input  wire sld_pkg::sld_in_t  sample,
  // result channel
  output logic                   result_valid,
  input  wire logic              result_ready,
  output sld_pkg::sld_out_t      result,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [63:0]       pwdata,
  output logic [63:0]            prdata,
  output logic                   pready
);
  import sld_pkg::*;

  // Only slots reachable by an 8-bit index need storage.
  localparam int DEPTH = (SLOT_COUNT < 256) ? SLOT_COUNT : 256;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers.
  logic [63:0] busy_threshold;
  logic [63:0] window_width;

  // Pipeline stage: item whose record read is in flight or just returned.
  logic        stage_valid;
  sld_in_t     stage_item;
  logic        stage_advance;

  // Last write to the record memory, kept for forwarding.
  logic        fwd_valid;
  logic [7:0]  fwd_slot;
  sld_rec_t    fwd_rec;

  sld_rec_t    mem_rec;
  sld_rec_t    cur_rec;
  sld_upd_t    upd;
  logic        sample_xfer;
  logic        cfg_write;

  // ---------------------------------------------------------------------------
  // Configuration port: zero wait states, 64-bit registers at 8-byte spacing.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_threshold <= BUSY_THRESHOLD_RESET;
      window_width   <= WINDOW_WIDTH_RESET;
    end else if (cfg_write) begin
      case (paddr[3])
        REG_BUSY_THRESHOLD: busy_threshold <= pwdata;
        REG_WINDOW_WIDTH:   window_width   <= pwdata;
        default:            busy_threshold <= busy_threshold;
      endcase
    end
  end

  assign prdata = (paddr[3] == REG_WINDOW_WIDTH) ? window_width : busy_threshold;

  // ---------------------------------------------------------------------------
  // Handshake. The stage advances whenever the output register is empty or
  // its result is being taken, so a new sample is taken every cycle while the
  // downstream side keeps up.
  // ---------------------------------------------------------------------------
  assign stage_advance = stage_valid && (!result_valid || result_ready);
  assign sample_ready  = !stage_valid || stage_advance;
  assign sample_xfer   = sample_valid && sample_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sample_ready) begin
      stage_valid <= sample_valid;
    end
  end

  // Hold the item while the stage is stalled.
  always_ff @(posedge clk) begin
    if (sample_xfer) begin
      stage_item <= sample;
    end
  end

  // ---------------------------------------------------------------------------
  // Record memory: read issued on the sample transfer, data registered by the memory and
  // returned in the stage, write-back when the stage advances.
  // ---------------------------------------------------------------------------
  sld_record_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (sample_xfer),
    .rd_addr (sample.slot_index[AW-1:0]),
    .rd_rec  (mem_rec),
    .wr_en   (stage_advance && upd.write),
    .wr_addr (stage_item.slot_index[AW-1:0]),
    .wr_rec  (upd.rec)
  );

  // The read for the stage item may have missed the write that retired on the
  // same edge; no other write can intervene while the item waits in the stage,
  // so the most recent write is the only one that can be missing.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (stage_advance && upd.write) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_advance && upd.write) begin
      fwd_slot <= stage_item.slot_index;
      fwd_rec  <= upd.rec;
    end
  end

  assign cur_rec = (fwd_valid && fwd_slot == stage_item.slot_index) ? fwd_rec : mem_rec;

  sld_update #(
    .DEPTH          (DEPTH),
    .TICKS_REQUIRED (TICKS_REQUIRED)
  ) u_update (
    .item           (stage_item),
    .rec            (cur_rec),
    .busy_threshold (busy_threshold),
    .window_width   (window_width),
    .upd            (upd)
  );

  // ---------------------------------------------------------------------------
  // Output register: load on stage advance, drop once transferred.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (stage_advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_advance) begin
      result <= upd.result;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sld_checker.sv =====
// Port-level checker for the spin loop detector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sld_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              result_valid,
  input wire logic              result_ready,
  input wire sld_pkg::sld_out_t result
);
  import sld_pkg::*;

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Reset empties the output.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A report only comes with a busy tick.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.spin_report |-> result.busy_tick)
    else $error("report without busy tick");

  // A quiet tick shows an empty window.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.busy_tick |->
      result.window_low == 64'd0 && result.window_high == 64'd0 &&
      result.window_span == 64'd0)
    else $error("window shown without busy tick");

  // Span is high minus low.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.window_span == result.window_high - result.window_low)
    else $error("window span mismatch");

endmodule

bind spin_loop_detector_core sld_checker u_sld_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the spin loop detector core.
`timescale 1ns / 1ps

module testbench;
  import sld_pkg::*;

  localparam int SLOT_COUNT     = 256;
  localparam int TICKS_REQUIRED = 4;
  localparam int HOT_SLOTS      = 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 6;
  localparam int CYCLE_LIMIT    = 250000;
  localparam int REPORT_LIMIT   = 10;

  // The command encoding leaves one value unused; the core must ignore it.
  localparam logic [1:0] CMD_IGNORED = 2'd3;

  typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_TOGGLE} sink_mode_e;

  // Per-slot record model plus the queue of results it still owes.
  class spin_tracker;
    logic [63:0] busy_limit;
    logic [63:0] span_limit;
    logic [63:0] last_count [SLOT_COUNT];
    logic [63:0] low_pc     [SLOT_COUNT];
    logic [63:0] high_pc    [SLOT_COUNT];
    logic [7:0]  tick_count [SLOT_COUNT];
    logic        reported   [SLOT_COUNT];
    sld_out_t    owed_results [$];
    int unsigned mismatches;
    int unsigned strays;

    function new();
      busy_limit  = BUSY_THRESHOLD_RESET;
      span_limit  = WINDOW_WIDTH_RESET;
      mismatches  = 0;
      strays      = 0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        wipe_slot(s);
      end
    endfunction

    function void wipe_slot(int unsigned s);
      last_count[s] = '0;
      low_pc[s]     = '0;
      high_pc[s]    = '0;
      tick_count[s] = '0;
      reported[s]   = 1'b0;
    endfunction

    function void set_config(logic idx, logic [63:0] value);
      case (idx)
        REG_BUSY_THRESHOLD: busy_limit = value;
        REG_WINDOW_WIDTH:   span_limit = value;
        default: ;
      endcase
    endfunction

    // Advance the slot record for one item and return the result it produces.
    function sld_out_t detect_spin(sld_in_t item);
      sld_out_t    res;
      int unsigned s;
      int unsigned ticks;
      logic [63:0] delta;
      res = '0;
      s = item.slot_index;
      if (s >= SLOT_COUNT) return res;
      case (item.command)
        CMD_ABSENT: begin
          tick_count[s] = '0;
          reported[s]   = 1'b0;
        end
        CMD_CLEAR: wipe_slot(s);
        CMD_SAMPLE: begin
          delta = item.retired_count - last_count[s];
          last_count[s] = item.retired_count;
          res.count_delta = delta;
          if (delta <= busy_limit) begin
            tick_count[s] = '0;
            reported[s]   = 1'b0;
            return res;
          end
          res.busy_tick = 1'b1;
          ticks = tick_count[s];
          if (ticks == 0) begin
            low_pc[s]  = item.pc_value;
            high_pc[s] = item.pc_value;
          end else begin
            if (item.pc_value < low_pc[s]) low_pc[s] = item.pc_value;
            if (item.pc_value > high_pc[s]) high_pc[s] = item.pc_value;
          end
          if (ticks < TICK_MAX) ticks++;
          tick_count[s] = 8'(ticks);
          if (high_pc[s] - low_pc[s] >= span_limit) begin
            low_pc[s]     = item.pc_value;
            high_pc[s]    = item.pc_value;
            tick_count[s] = 8'd1;
            reported[s]   = 1'b0;
          end else if (ticks >= TICKS_REQUIRED && !reported[s]) begin
            reported[s]     = 1'b1;
            res.spin_report = 1'b1;
          end
          res.window_low  = low_pc[s];
          res.window_high = high_pc[s];
          res.window_span = high_pc[s] - low_pc[s];
        end
        default: ;
      endcase
      return res;
    endfunction

    function void note_sample(sld_in_t item);
      owed_results.insert(owed_results.size(), detect_spin(item));
    endfunction

    function void check_result(sld_out_t got);
      sld_out_t exp;
      if (owed_results.size() == 0) begin
        strays++;
        if (mismatches + strays <= REPORT_LIMIT)
          $display("unexpected result: report=%0b busy=%0b delta=%h",
                   got.spin_report, got.busy_tick, got.count_delta);
        return;
      end
      exp = owed_results.pop_front();
      if (got.spin_report !== exp.spin_report || got.busy_tick !== exp.busy_tick ||
          got.count_delta !== exp.count_delta || got.window_low !== exp.window_low ||
          got.window_high !== exp.window_high || got.window_span !== exp.window_span) begin
        mismatches++;
        if (mismatches + strays <= REPORT_LIMIT) begin
          $display("mismatch expected: report=%0b busy=%0b delta=%h low=%h high=%h span=%h",
                   exp.spin_report, exp.busy_tick, exp.count_delta,
                   exp.window_low, exp.window_high, exp.window_span);
          $display("         actual:   report=%0b busy=%0b delta=%h low=%h high=%h span=%h",
                   got.spin_report, got.busy_tick, got.count_delta,
                   got.window_low, got.window_high, got.window_span);
        end
      end
    endfunction

    function int unsigned outstanding();
      return owed_results.size();
    endfunction

    function int unsigned failures();
      return mismatches + strays + owed_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        sample_valid;
  logic        sample_ready;
  sld_in_t     sample;
  logic        result_valid;
  logic        result_ready;
  sld_out_t    result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  spin_tracker tracker = new();

  // Stimulus bookkeeping: burst pacing, the hot slots of the current phase
  // and a base program counter per slot around which narrow loops are built.
  int unsigned items_sent   = 0;
  int unsigned burst_left   = 0;
  bit          steady       = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned cycle_count  = 0;
  logic [7:0]  hot_slot [HOT_SLOTS];
  logic [63:0] pc_base  [SLOT_COUNT];

  spin_loop_detector_core #(
    .SLOT_COUNT     (SLOT_COUNT),
    .TICKS_REQUIRED (TICKS_REQUIRED)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk = ~clk;

  // Abort a hung run; the limit is many times the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Check every result transfer against the oldest owed result.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) tracker.check_result(result);
  end

  // Result sink: rotate through stall patterns, each held for a random stretch.
  // On request, hold off completely so the core backs up.
  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned left;
    result_ready = 1'b0;
    mode = SINK_OPEN;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        result_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        if (left == 0) begin
          mode = sink_mode_e'($urandom_range(0, 3));
          left = $urandom_range(16, 96);
        end
        left--;
        case (mode)
          SINK_OPEN:   result_ready = 1'b1;
          SINK_COIN:   result_ready = 1'($urandom_range(0, 1));
          SINK_SPARSE: result_ready = ($urandom_range(0, 3) == 0);
          default:     result_ready = ~result_ready;
        endcase
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic sld_in_t mk(logic [1:0] cmd, logic [7:0] slot,
                                 logic [63:0] pc, logic [63:0] cnt);
    sld_in_t item;
    item.command       = cmd;
    item.slot_index    = slot;
    item.pc_value      = pc;
    item.retired_count = cnt;
    return item;
  endfunction

  // Pick the next retired count for a slot so the delta lands above the
  // threshold (busy) or at/below it; a threshold at all ones can never be beaten.
  function automatic logic [63:0] next_count(int unsigned s, bit busy);
    logic [63:0] thr;
    logic [63:0] d;
    thr = tracker.busy_limit;
    if (busy && thr != '1) begin
      if ($urandom_range(0, 1) && ~thr > 64'd1000) d = 64'($urandom_range(0, 999));
      else d = rand64() % ~thr;
      d = thr + 64'd1 + d;
    end else if (thr == '1) begin
      d = rand64();
    end else if ($urandom_range(0, 3) == 0) begin
      d = thr;
    end else begin
      d = rand64() % (thr + 64'd1);
    end
    return tracker.last_count[s] + d;
  endfunction

  // Narrow pcs stay within the window width above the slot base (below 16 above it at zero width); others jump out.
  function automatic logic [63:0] next_pc(int unsigned s, bit narrow);
    logic [63:0] w;
    logic [63:0] off;
    w = tracker.span_limit;
    if (!narrow) off = w + 64'($urandom_range(0, 4095));
    else if (w == 0) off = 64'($urandom_range(0, 15));
    else off = rand64() % w;
    return pc_base[s] + off;
  endfunction

  // Offer one item, hold it until the transfer, then pace the next burst.
  task automatic send_item(input sld_in_t item);
    @(negedge clk);
    sample_valid = 1'b1;
    sample = item;
    do @(posedge clk); while (!sample_ready);
    tracker.note_sample(item);
    items_sent++;
    if (!steady) begin
      if (burst_left == 0) begin
        repeat ($urandom_range(1, 7)) begin
          @(negedge clk);
          sample_valid = 1'b0;
        end
        burst_left = $urandom_range(0, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic drain(input int unsigned settle);
    @(negedge clk);
    sample_valid = 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [63:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_config(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Quiesce, load both registers, and pick fresh hot slots for the next phase.
  task automatic configure(input logic [63:0] thr, input logic [63:0] width);
    drain(SETTLE_CYCLES);
    write_reg(REG_BUSY_THRESHOLD, thr);
    write_reg(REG_WINDOW_WIDTH, width);
    for (int i = 0; i < HOT_SLOTS; i++) begin
      hot_slot[i] = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
        0:       pc_base[hot_slot[i]] = '0;
        1:       pc_base[hot_slot[i]] = '1 - 64'($urandom_range(0, 8191));
        default: pc_base[hot_slot[i]] = rand64();
      endcase
    end
  endtask

  // Mostly loops on hot slots with narrow pcs and busy deltas, sprinkled with
  // idle ticks, absent and clear commands, and fully random noise items.
  task automatic run_phase(input int unsigned n);
    int unsigned goal;
    int unsigned pick;
    int unsigned len;
    int unsigned s;
    goal = items_sent + n;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      s = hot_slot[$urandom_range(0, HOT_SLOTS - 1)];
      if (pick < 72) begin
        len = $urandom_range(2, 12);
        repeat (len) begin
          pick = $urandom_range(0, 99);
          if (pick < 4) send_item(mk(CMD_ABSENT, 8'(s), rand64(), rand64()));
          else send_item(mk(CMD_SAMPLE, 8'(s), next_pc(s, pick >= 12),
                            next_count(s, pick >= 8)));
        end
      end else if (pick < 82) begin
        send_item(mk(pick < 78 ? CMD_ABSENT : CMD_CLEAR, 8'(s), rand64(), rand64()));
      end else begin
        send_item(mk(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     rand64(), rand64()));
      end
    end
  endtask

  // Walk slot 0 through threshold edges, a re-seed, a report and its latch,
  // then the command corner cases and counter wrap on the slot extremes.
  task automatic directed();
    logic [63:0] c;
    c = 64'd0;
    send_item(mk(CMD_SAMPLE, 8'd0, 64'h1234, c));
    c += 64'd2000000;
    send_item(mk(CMD_SAMPLE, 8'd0, 64'h1234, c));
    c += 64'd2000001;
    send_item(mk(CMD_SAMPLE, 8'd0, 64'h1000, c));
    c += 64'd3000000;
    send_item(mk(CMD_SAMPLE, 8'd0, 64'h1800, c));
    c += 64'd3000000;
    send_item(mk(CMD_SAMPLE, 8'd0, 64'h0800, c));
    c += 64'd3000000;
    send_item(mk(CMD_SAMPLE, 8'd0, 64'h0900, c));
    c += 64'd3000000;
    send_item(mk(CMD_SAMPLE, 8'd0, 64'h0a00, c));
    c += 64'd3000000;
    send_item(mk(CMD_SAMPLE, 8'd0, 64'h0fff, c));
    c += 64'd3000000;
    send_item(mk(CMD_SAMPLE, 8'd0, 64'h0c00, c));
    send_item(mk(CMD_ABSENT, 8'd0, '1, '1));
    send_item(mk(CMD_IGNORED, 8'd0, '1, '1));
    c += 64'd3000000;
    send_item(mk(CMD_SAMPLE, 8'd0, 64'd0, c));
    send_item(mk(CMD_CLEAR, 8'd0, '1, '1));
    send_item(mk(CMD_SAMPLE, 8'd0, '1, '1));
    send_item(mk(CMD_SAMPLE, 8'd0, 64'd0, 64'd5));
    send_item(mk(CMD_SAMPLE, 8'd255, '1, '1));
    send_item(mk(CMD_SAMPLE, 8'd255, 64'd0, 64'd2999999));
    send_item(mk(CMD_ABSENT, 8'd255, 64'd0, 64'd0));
    send_item(mk(CMD_CLEAR, 8'd128, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555));
    send_item(mk(CMD_IGNORED, 8'd255, 64'd0, 64'd0));
  endtask

  // Drive one slot past the tick counter ceiling with a constant pc.
  task automatic saturate_ticks();
    int unsigned s;
    s = hot_slot[0];
    repeat (262) send_item(mk(CMD_SAMPLE, 8'(s), pc_base[s], tracker.last_count[s] + 64'd1));
  endtask

  initial begin
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    for (int s = 0; s < SLOT_COUNT; s++) pc_base[s] = rand64();
    for (int i = 0; i < HOT_SLOTS; i++) hot_slot[i] = 8'($urandom_range(0, 255));
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed();
    run_phase(230);

    // Zero threshold with the widest window: any forward progress is busy.
    configure(64'd0, '1);
    saturate_ticks();
    run_phase(200);

    // Threshold at all ones never goes busy; zero width re-seeds every busy tick.
    configure('1, 64'd0);
    run_phase(100);
    configure(64'd100, 64'd0);
    run_phase(150);

    // Tight window; back the core up behind a stalled sink, then pause the
    // sender until everything has drained.
    configure(64'd1000, 64'd16);
    run_phase(120);
    hold_request = 1'b1;
    steady = 1'b1;
    run_phase(80);
    steady = 1'b0;
    drain(0);
    run_phase(120);

    configure(64'($urandom_range(0, 5000000)), 64'($urandom_range(1, 1 << 20)));
    run_phase(250);
    configure(BUSY_THRESHOLD_RESET, WINDOW_WIDTH_RESET);
    run_phase(250);

    drain(SETTLE_CYCLES);
    if (tracker.failures() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
